// ===== sv/smwr_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment map package
// Shared constants, operation and status codes, and the transfer types that
// pass between the front end, the back end and the result queue.
// ----------------------------------------------------------------------------
package smwr_pkg;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_MAX_WORDS    = 1024;
  localparam int DEF_WORD_BYTES   = 4;

  // Widest internal fields over the parameter ranges.
  localparam int SEG_MAX_W = 12;
  localparam int OFF_MAX_W = 16;
  localparam int LEN_MAX_W = 17;

  localparam logic [2:0] OP_MAP    = 3'd0;
  localparam logic [2:0] OP_UNMAP  = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_LOAD   = 3'd4;
  localparam logic [2:0] OP_SIZE   = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SEG  = 3'd1;
  localparam logic [2:0] ST_BAD_OFF  = 3'd2;
  localparam logic [2:0] ST_NO_ID    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_FILL  = 3'd3;
  localparam logic [2:0] CMD_COPY  = 3'd4;

  typedef struct packed {
    logic [2:0]           kind;
    logic [2:0]           status;
    logic [31:0]          data;
    logic [SEG_MAX_W-1:0] seg;
    logic [OFF_MAX_W-1:0] off;
    logic [31:0]          val;
    logic [LEN_MAX_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  status;
  } result_t;

endpackage

// ===== sv/segment_map_with_id_recycling.sv =====
// ----------------------------------------------------------------------------
// Segmented word memory with id recycling
// Maps, frees, reads, writes, sizes and loads segments of a word store.
//
//   Channel   Handshake        Payload
//   request   push / full      operation, segment_id, offset, value, length
//   result    pop / empty      data, status
//
// The front end takes a new request only once it has handed the last one to
// the command queue, and waits there while that queue is full. Write, size,
// unmap, unknown codes and errors are answered as the back end takes the
// command; a read first passes the read state for the registered store data.
// Map zero fills the new segment, load program copies a segment over segment
// zero, each one word a cycle. After reset the segment table is cleared entry
// by entry, during which full stays high. Either side may stall on its own.
// ----------------------------------------------------------------------------
module segment_map_with_id_recycling #(
  parameter int MAX_SEGMENTS = smwr_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_WORDS    = smwr_pkg::DEF_MAX_WORDS,
  parameter int WORD_BYTES   = smwr_pkg::DEF_WORD_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] segment_id,
  input  logic [31:0] offset,
  input  logic [31:0] value,
  input  logic [31:0] length,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] data,
  output logic [2:0]  status
);

  import smwr_pkg::*;

  cmd_t    cmd_in;
  cmd_t    cmd_out;
  logic    cmd_push;
  logic    cmd_full;
  logic    cmd_pop;
  logic    cmd_empty;
  result_t res_in;
  result_t res_out;
  logic    res_push;
  logic    res_full;

  smwr_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_WORDS    (MAX_WORDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .segment_id (segment_id),
    .offset     (offset),
    .value      (value),
    .length     (length),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .cmd_full   (cmd_full)
  );

  smwr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  smwr_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_WORDS    (MAX_WORDS),
    .WORD_BYTES   (WORD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  smwr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign data   = res_out.data;
  assign status = res_out.status;

endmodule

// ===== sv/smwr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/smwr_fifo.sv =====
// ----------------------------------------------------------------------------
// Small register queue
// A short first-in first-out queue that decouples a producer and a consumer.
// ----------------------------------------------------------------------------
module smwr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/smwr_front.sv =====
// ----------------------------------------------------------------------------
// Segment map front end
// Accepts requests, checks them against the segment table, allocates and
// frees ids, and hands a command for each request to the back end.
// ----------------------------------------------------------------------------
module smwr_front #(
  parameter int MAX_SEGMENTS = 64,
  parameter int MAX_WORDS    = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [2:0]     operation,
  input  logic [31:0]    segment_id,
  input  logic [31:0]    offset,
  input  logic [31:0]    value,
  input  logic [31:0]    length,
  output logic           cmd_push,
  output smwr_pkg::cmd_t cmd,
  input  logic           cmd_full
);

  import smwr_pkg::*;

  localparam int SEG_W     = $clog2(MAX_SEGMENTS);
  localparam int OFF_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LEN_W     = $clog2(MAX_WORDS + 1);
  localparam int TBL_DEPTH = 1 << SEG_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0]       state;
  logic [SEG_W:0]   clr_idx;
  logic [2:0]       op_q;
  logic [31:0]      id_q;
  logic [31:0]      off_q;
  logic [31:0]      val_q;
  logic [31:0]      len_q;
  logic [SEG_W:0]   free_count;
  logic [SEG_W:0]   issued_count;

  logic             tbl_we;
  logic [SEG_W-1:0] tbl_waddr;
  logic [LEN_W:0]   tbl_wdata;
  logic [SEG_W-1:0] tbl_raddr;
  logic [LEN_W:0]   tbl_rdata;
  logic             stk_we;
  logic [SEG_W-1:0] stk_raddr;
  logic [SEG_W-1:0] stk_rdata;

  logic             go;
  logic             mapped;
  logic [LEN_W-1:0] seg_len;
  logic             in_range;
  logic             seg_ok;
  logic [SEG_W-1:0] new_id;
  logic             tbl_set;
  logic [SEG_W-1:0] tbl_set_addr;
  logic [LEN_W:0]   tbl_set_data;
  logic             stk_push;
  logic             stk_pop;
  logic             issue;
  logic             load_issue;

  assign full      = (state != S_IDLE);
  assign go        = (state == S_LOOK) && !cmd_full;
  assign cmd_push  = go;
  assign tbl_raddr = (state == S_IDLE) ? segment_id[SEG_W-1:0] : id_q[SEG_W-1:0];
  assign stk_raddr = SEG_W'(free_count - 1'b1);

  assign mapped   = tbl_rdata[LEN_W];
  assign seg_len  = tbl_rdata[LEN_W-1:0];
  assign in_range = (id_q < 32'(MAX_SEGMENTS));
  assign seg_ok   = in_range && mapped;
  assign new_id   = (free_count != '0) ? stk_rdata : issued_count[SEG_W-1:0];

  always_comb begin
    cmd          = '0;
    cmd.kind     = CMD_NONE;
    cmd.status   = ST_OK;
    cmd.seg      = SEG_MAX_W'(id_q[SEG_W-1:0]);
    cmd.off      = OFF_MAX_W'(off_q[OFF_W-1:0]);
    cmd.val      = val_q;
    tbl_set      = 1'b0;
    tbl_set_addr = id_q[SEG_W-1:0];
    tbl_set_data = '0;
    stk_push     = 1'b0;
    stk_pop      = 1'b0;
    issue        = 1'b0;
    load_issue   = 1'b0;
    case (op_q)
      OP_MAP: begin
        if (len_q > 32'(MAX_WORDS)) begin
          cmd.status = ST_TOO_LONG;
        end else if (free_count != '0 || issued_count < (SEG_W + 1)'(MAX_SEGMENTS)) begin
          cmd.kind     = CMD_FILL;
          cmd.seg      = SEG_MAX_W'(new_id);
          cmd.count    = LEN_MAX_W'(len_q[LEN_W-1:0]);
          cmd.data     = 32'(new_id);
          tbl_set      = 1'b1;
          tbl_set_addr = new_id;
          tbl_set_data = {1'b1, len_q[LEN_W-1:0]};
          stk_pop      = (free_count != '0);
          issue        = (free_count == '0);
        end else begin
          cmd.status = ST_NO_ID;
        end
      end
      OP_UNMAP: begin
        if (!in_range) begin
          cmd.status = ST_BAD_SEG;
        end else if (mapped) begin
          tbl_set  = 1'b1;
          stk_push = (id_q != '0) && (free_count < (SEG_W + 1)'(MAX_SEGMENTS));
        end
      end
      OP_READ, OP_WRITE: begin
        if (!seg_ok) begin
          cmd.status = ST_BAD_SEG;
        end else if (off_q >= 32'(seg_len)) begin
          cmd.status = ST_BAD_OFF;
        end else begin
          cmd.kind = (op_q == OP_READ) ? CMD_READ : CMD_WRITE;
        end
      end
      OP_LOAD: begin
        if (id_q == '0) begin
          cmd.status = ST_OK;
        end else if (!seg_ok) begin
          cmd.status = ST_BAD_SEG;
        end else begin
          cmd.kind     = CMD_COPY;
          cmd.count    = LEN_MAX_W'(seg_len);
          tbl_set      = 1'b1;
          tbl_set_addr = '0;
          tbl_set_data = {1'b1, seg_len};
          load_issue   = (issued_count == '0);
        end
      end
      OP_SIZE: begin
        if (!seg_ok) begin
          cmd.status = ST_BAD_SEG;
        end else begin
          cmd.data = 32'(seg_len);
        end
      end
      default: begin
        cmd.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    if (state == S_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_idx[SEG_W-1:0];
      tbl_wdata = '0;
    end else begin
      tbl_we    = go && tbl_set;
      tbl_waddr = tbl_set_addr;
      tbl_wdata = tbl_set_data;
    end
  end

  assign stk_we = go && stk_push;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      op_q  <= operation;
      id_q  <= segment_id;
      off_q <= offset;
      val_q <= value;
      len_q <= length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      free_count   <= '0;
      issued_count <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (SEG_W + 1)'(TBL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (push) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (go) begin
            state <= S_IDLE;
            if (stk_push) begin
              free_count <= free_count + 1'b1;
            end else if (stk_pop) begin
              free_count <= free_count - 1'b1;
            end
            if (issue) begin
              issued_count <= issued_count + 1'b1;
            end else if (load_issue) begin
              issued_count <= (SEG_W + 1)'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  smwr_ram #(
    .WIDTH (LEN_W + 1),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  smwr_ram #(
    .WIDTH (SEG_W),
    .DEPTH (TBL_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (free_count[SEG_W-1:0]),
    .wdata (id_q[SEG_W-1:0]),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

// ===== sv/smwr_back.sv =====
// ----------------------------------------------------------------------------
// Segment map back end
// Carries out commands on the word store: single reads and writes, the zero
// fill of a new segment and the copy of a segment over segment zero.
// ----------------------------------------------------------------------------
module smwr_back #(
  parameter int MAX_SEGMENTS = 64,
  parameter int MAX_WORDS    = 1024,
  parameter int WORD_BYTES   = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  smwr_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output smwr_pkg::result_t res
);

  import smwr_pkg::*;

  localparam int SEG_W  = $clog2(MAX_SEGMENTS);
  localparam int OFF_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LEN_W  = $clog2(MAX_WORDS + 1);
  localparam int WORD_W = (WORD_BYTES >= 4) ? 32 : 8 * WORD_BYTES;
  localparam int ADDR_W = SEG_W + OFF_W;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_FILL = 2'd2;
  localparam logic [1:0] B_COPY = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  cmd_t              cur;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  idx_next;
  logic              wr_pend;
  logic              wr_pend_next;
  logic [OFF_W-1:0]  wr_idx;
  logic              take;
  logic [LEN_W-1:0]  cur_count;

  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [WORD_W-1:0] st_wdata;
  logic [ADDR_W-1:0] st_raddr;
  logic [WORD_W-1:0] st_rdata;

  assign take      = (state == B_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop   = take;
  assign cur_count = cur.count[LEN_W-1:0];

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    wr_pend_next = 1'b0;
    st_we        = 1'b0;
    st_waddr     = {cmd.seg[SEG_W-1:0], cmd.off[OFF_W-1:0]};
    st_wdata     = cmd.val[WORD_W-1:0];
    st_raddr     = {cmd.seg[SEG_W-1:0], cmd.off[OFF_W-1:0]};
    res_push     = 1'b0;
    res.data     = cur.data;
    res.status   = cur.status;
    case (state)
      B_IDLE: begin
        if (take) begin
          idx_next = '0;
          case (cmd.kind)
            CMD_READ: begin
              state_next = B_READ;
            end
            CMD_WRITE: begin
              st_we      = 1'b1;
              res_push   = 1'b1;
              res.data   = cmd.data;
              res.status = cmd.status;
            end
            CMD_FILL: begin
              state_next = B_FILL;
            end
            CMD_COPY: begin
              state_next = B_COPY;
            end
            default: begin
              res_push   = 1'b1;
              res.data   = cmd.data;
              res.status = cmd.status;
            end
          endcase
        end
      end
      B_READ: begin
        res_push   = 1'b1;
        res.data   = 32'(st_rdata);
        state_next = B_IDLE;
      end
      B_FILL: begin
        if (idx == cur_count) begin
          res_push   = 1'b1;
          state_next = B_IDLE;
        end else begin
          st_we    = 1'b1;
          st_waddr = {cur.seg[SEG_W-1:0], idx[OFF_W-1:0]};
          st_wdata = '0;
          idx_next = idx + 1'b1;
        end
      end
      B_COPY: begin
        st_raddr = {cur.seg[SEG_W-1:0], idx[OFF_W-1:0]};
        st_waddr = {SEG_W'(0), wr_idx};
        st_wdata = st_rdata;
        st_we    = wr_pend;
        if (idx != cur_count) begin
          idx_next     = idx + 1'b1;
          wr_pend_next = 1'b1;
        end else if (!wr_pend) begin
          res_push   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= cmd;
    end
    idx    <= idx_next;
    wr_idx <= idx[OFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= wr_pend_next;
    end
  end

  smwr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (1 << ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

endmodule

// ===== sv/smwr_checker.sv =====
// ----------------------------------------------------------------------------
// Segment map port checker
// Watches the ports of the segment map over time.
// ----------------------------------------------------------------------------
module smwr_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [31:0] data,
  input logic [2:0]  status
);

  import smwr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_busy: assert property (@(posedge clk) rst |=> full)
    else $error("request accepted during table clear");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status <= ST_TOO_LONG))
    else $error("status code out of range");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (data == '0))
    else $error("error result carries data");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(data) && $stable(status)))
    else $error("waiting result changed before its transfer");

endmodule

bind segment_map_with_id_recycling smwr_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .data   (data),
  .status (status)
);

// ===== tb/tb_segment_map_with_id_recycling.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment map testbench
// Drives map, unmap, read, write, load program, size and unknown-code requests through the
// request queue, predicts every result with a model of the segment table, the
// free id stack and the word store, and compares each transfer on the result
// queue against it. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_segment_map_with_id_recycling;
  import smwr_pkg::*;

  localparam int NUM_SEGS    = DEF_MAX_SEGMENTS;
  localparam int SEG_WORDS   = DEF_MAX_WORDS;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 8000000;
  localparam int DRAIN_CYCLES = 1200;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  class seg_map_scoreboard;
    bit [31:0] words[NUM_SEGS*SEG_WORDS];
    bit [10:0] seg_len[NUM_SEGS];
    bit        mapped[NUM_SEGS];
    bit [5:0]  free_ids[NUM_SEGS];
    int        free_count;
    int        issued_count;
    bit [34:0] pending_results[$];
    int        errors;

    function new();
      free_count   = 0;
      issued_count = 0;
      errors       = 0;
      foreach (mapped[i]) begin
        mapped[i]  = 0;
        seg_len[i] = 0;
      end
    endfunction

    function void note_input(logic [2:0] op, logic [31:0] id, logic [31:0] off,
                             logic [31:0] val, logic [31:0] len);
      bit [31:0] d;
      bit [2:0]  s;
      int        nid;
      bit        ok_seg;
      d = 0;
      s = ST_OK;
      nid = -1;
      ok_seg = (id < NUM_SEGS) && mapped[id];
      case (op)
        OP_MAP: begin
          if (len > SEG_WORDS) s = ST_TOO_LONG;
          else if (free_count > 0) begin
            free_count--;
            nid = free_ids[free_count];
          end else if (issued_count < NUM_SEGS) begin
            nid = issued_count;
            issued_count++;
          end else s = ST_NO_ID;
          if (nid >= 0) begin
            for (int i = 0; i < len; i++) words[nid*SEG_WORDS+i] = 0;
            seg_len[nid] = len;
            mapped[nid]  = 1;
            d = nid;
          end
        end
        OP_UNMAP: begin
          if (id >= NUM_SEGS) s = ST_BAD_SEG;
          else if (mapped[id]) begin
            mapped[id]  = 0;
            seg_len[id] = 0;
            if (id != 0 && free_count < NUM_SEGS) begin
              free_ids[free_count] = id;
              free_count++;
            end
          end
        end
        OP_READ, OP_WRITE: begin
          if (!ok_seg) s = ST_BAD_SEG;
          else if (off >= seg_len[id]) s = ST_BAD_OFF;
          else if (op == OP_READ) d = words[id*SEG_WORDS+off];
          else words[id*SEG_WORDS+off] = val;
        end
        OP_LOAD: begin
          if (id != 0) begin
            if (!ok_seg) s = ST_BAD_SEG;
            else begin
              for (int i = 0; i < seg_len[id]; i++) words[i] = words[id*SEG_WORDS+i];
              seg_len[0] = seg_len[id];
              mapped[0]  = 1;
              if (issued_count == 0) issued_count = 1;
            end
          end
        end
        OP_SIZE: begin
          if (!ok_seg) s = ST_BAD_SEG;
          else d = seg_len[id];
        end
        default: ;
      endcase
      pending_results.push_back({d, s});
    endfunction

    function void check_result(logic [31:0] d, logic [2:0] s);
      bit [34:0] want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result transfer: data %h status %0d", d, s);
      end else begin
        want = pending_results.pop_front();
        if (d !== want[34:3] || s !== want[2:0]) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected data %h status %0d, got data %h status %0d",
                     want[34:3], want[2:0], d, s);
        end
      end
    endfunction

    function logic [31:0] pick_mapped();
      int ids[$];
      foreach (mapped[i]) if (mapped[i]) ids.push_back(i);
      if (ids.size() == 0) return $urandom_range(0, NUM_SEGS - 1);
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        pop = 0;
  logic [2:0]  operation = 0;
  logic [31:0] segment_id = 0;
  logic [31:0] offset = 0;
  logic [31:0] value = 0;
  logic [31:0] length = 0;
  logic        full;
  logic        empty;
  logic [31:0] data;
  logic [2:0]  status;

  seg_map_scoreboard sb = new();
  int cycles = 0;
  int pop_hold = 0;

  segment_map_with_id_recycling DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .segment_id(segment_id), .offset(offset), .value(value), .length(length),
    .pop(pop), .empty(empty), .data(data), .status(status)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** segment_map_with_id_recycling: FAILED **");
      $finish;
    end
  end

  function int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_result(data, status);
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 0;
      end else begin
        pop <= 1;
        if ($urandom_range(0, 3) == 0) pop_hold = gap_length();
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [31:0] id, logic [31:0] off,
                           logic [31:0] val, logic [31:0] len, bit quiet = 0);
    int gap;
    push       <= 1;
    operation  <= op;
    segment_id <= id;
    offset     <= off;
    value      <= val;
    length     <= len;
    do @(posedge clk); while (full);
    sb.note_input(op, id, off, val, len);
    gap = quiet ? 0 : gap_length();
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int r;
    logic [2:0]  op;
    logic [31:0] id, off, len;
    r = $urandom_range(0, 99);
    if (r < 20) op = OP_MAP;
    else if (r < 32) op = OP_UNMAP;
    else if (r < 57) op = OP_READ;
    else if (r < 82) op = OP_WRITE;
    else if (r < 88) op = OP_LOAD;
    else if (r < 96) op = OP_SIZE;
    else op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
    r = $urandom_range(0, 99);
    if (r < 65) id = sb.pick_mapped();
    else if (r < 90) id = $urandom_range(0, NUM_SEGS + 3);
    else id = $urandom;
    r = $urandom_range(0, 99);
    if (r < 75 && id < NUM_SEGS) off = $urandom_range(0, sb.seg_len[id]);
    else if (r < 90) off = $urandom_range(0, SEG_WORDS + 2);
    else off = $urandom;
    r = $urandom_range(0, 99);
    if (r < 78) len = $urandom_range(0, 12);
    else if (r < 86) len = $urandom_range(13, SEG_WORDS);
    else if (r < 90) len = SEG_WORDS;
    else if (r < 95) len = $urandom_range(SEG_WORDS + 1, SEG_WORDS + 100);
    else len = $urandom;
    send_item(op, id, off, $urandom, len, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    send_item(OP_MAP, 0, 0, 0, 4);
    send_item(OP_MAP, 32'hFFFF_FFFF, 0, 0, 0);
    send_item(OP_MAP, 0, 0, 0, SEG_WORDS);
    send_item(OP_MAP, 0, 0, 0, SEG_WORDS + 1);
    send_item(OP_MAP, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 2, SEG_WORDS - 1, 32'hFFFF_FFFF, 0);
    send_item(OP_WRITE, 2, 0, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_READ, 2, SEG_WORDS - 1, 0, 0);
    send_item(OP_READ, 2, SEG_WORDS, 0, 0);
    send_item(OP_READ, 1, 0, 0, 0);
    send_item(OP_READ, 2, 32'hFFFF_FFFF, 0, 0);
    send_item(OP_READ, NUM_SEGS, 0, 0, 0);
    send_item(OP_WRITE, 32'hFFFF_FFFF, 0, 32'h5A5A_A5A5, 0);
    send_item(OP_SIZE, 2, 0, 0, 0);
    send_item(OP_UNMAP, 5, 0, 0, 0);
    send_item(OP_UNMAP, NUM_SEGS + 6, 0, 0, 0);
    send_item(OP_LOAD, 2, 0, 0, 0);
    send_item(OP_LOAD, 0, 0, 0, 0);
    send_item(OP_UNMAP, 0, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0, 0);
    send_item(OP_LOAD, 9, 0, 0, 0);
    send_item(OP_LOAD, 1, 0, 0, 0);
    send_item(OP_UNMAP, 1, 0, 0, 0);
    send_item(OP_MAP, 0, 0, 0, 3);
    send_item(OP_SPARE_LO, 1, 0, 0, 0);
    send_item(OP_SPARE_HI, 1, 0, 0, 0);
    repeat (RANDOM_ITEMS) send_random();
    push <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("** segment_map_with_id_recycling: PASSED **");
    end else begin
      $display("** segment_map_with_id_recycling: FAILED **");
    end
    $finish;
  end
endmodule
